// ----- hdl/crat_pkg.sv -----
`default_nettype none
package crat_pkg;

  // characters of interest on the receive line
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_O  = 8'h4F;
  localparam logic [7:0] CH_K  = 8'h4B;

  // line capacity: a character that arrives at count LINE_CAPACITY-1 wraps the count
  localparam logic [3:0] LINE_CAPACITY = 4'd10;

  localparam logic [15:0] TIMEOUT_RELOAD_RST = 16'd10000;
  localparam logic [3:0]  MAX_ATTEMPTS_RST   = 4'd10;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT_RELOAD = 1'b0,
    CFG_MAX_ATTEMPTS   = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    FN_START = 2'd0,
    FN_BYTE  = 2'd1,
    FN_TICK  = 2'd2,
    FN_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RECV = 2'd1,
    PH_CR   = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    OUT_OK     = 2'd0,
    OUT_RESEND = 2'd1,
    OUT_GAVEUP = 2'd2
  } outcome_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0] outcome;
    logic [3:0] attempt_number;
  } out_word_t;

endpackage
`default_nettype wire

// ----- hdl/crlf_response_ack_tracker_unit.sv -----
// Reply tracker for a line-based command link. Each input word is a start
// (opens attempt 1), a received byte (builds the CR-LF terminated line, only
// the first two characters are kept), a wait tick (consumes a complete line
// or counts the timeout down) or a no-op. A tick that concludes an attempt
// gives one result word: ok if the line began with "OK", resend, or gave
// up once max_attempts is used up. Ticks while the receiver is idle never
// time out. Every input word is held in the input register, and the result
// it gives, if any, is written from there to the result register. The unit
// takes a word every cycle unless a stalled result holds the pipe, which
// happens only once the input register is also full. Registers (cfg_index):
// 0 timeout_reload (16 bit, reset 10000), 1 max_attempts (4 bit, reset 10);
// write them only while no word is in flight. cfg_ready is always high.
`default_nettype none
module crlf_response_ack_tracker_unit (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  input  crat_pkg::in_word_t                in_word,
  output logic                              in_stall,
  output logic                              out_valid,
  output crat_pkg::out_word_t               out_word,
  input  wire                               out_stall,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire [crat_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [crat_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import crat_pkg::*;

  logic      word_valid;
  in_word_t  word;
  logic      advance;
  logic      res_valid;
  out_word_t res;

  assign cfg_ready = 1'b1;

  crat_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_word    (in_word),
    .in_stall   (in_stall),
    .advance    (advance),
    .word_valid (word_valid),
    .word       (word)
  );

  crat_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .go        (advance),
    .word      (word),
    .res_valid (res_valid),
    .res       (res)
  );

  crat_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .word_valid (word_valid),
    .res_valid  (res_valid),
    .res        (res),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_word   (out_word),
    .out_stall  (out_stall)
  );

endmodule
`default_nettype wire

// ----- hdl/crat_in_reg.sv -----
`default_nettype none
module crat_in_reg (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  crat_pkg::in_word_t   in_word,
  output logic                 in_stall,
  input  wire                  advance,
  output logic                 word_valid,
  output crat_pkg::in_word_t   word
);
  import crat_pkg::*;

  logic     valid_r;
  in_word_t word_r;

  // holds while the core cannot take the registered word
  assign in_stall   = valid_r && !advance;
  assign word_valid = valid_r;
  assign word       = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      word_r <= in_word;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/crat_core.sv -----
`default_nettype none
module crat_core (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_we,
  input  wire [crat_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [crat_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire                                go,
  input  crat_pkg::in_word_t                 word,
  output logic                               res_valid,
  output crat_pkg::out_word_t                res
);
  import crat_pkg::*;

  logic [15:0] timeout_reload_r;
  logic [3:0]  max_attempts_r;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  count_r, count_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [7:0]  second_r, second_nxt;
  logic [15:0] timeout_r, timeout_nxt;
  logic [3:0]  attempt_r, attempt_nxt;
  logic        waiting_r, waiting_nxt;

  logic        store;
  logic [7:0]  store_char;
  logic        fail;
  logic [15:0] timeout_dec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_reload_r <= TIMEOUT_RELOAD_RST;
      max_attempts_r   <= MAX_ATTEMPTS_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TIMEOUT_RELOAD: timeout_reload_r <= cfg_data;
        CFG_MAX_ATTEMPTS:   max_attempts_r   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign timeout_dec = timeout_r - 16'd1;

  always_comb begin
    phase_nxt   = phase_r;
    count_nxt   = count_r;
    timeout_nxt = timeout_r;
    attempt_nxt = attempt_r;
    waiting_nxt = waiting_r;
    store       = 1'b0;
    store_char  = word.rx_byte;
    fail        = 1'b0;
    res_valid   = 1'b0;
    res.outcome        = OUT_OK;
    res.attempt_number = attempt_r;

    case (func_t'(word.func))
      FN_START: begin
        waiting_nxt = 1'b1;
        attempt_nxt = 4'd1;
      end
      FN_BYTE: begin
        case (phase_r)
          PH_IDLE: begin
            if (word.rx_byte != CH_CR && word.rx_byte != CH_LF) begin
              store       = 1'b1;
              count_nxt   = count_r + 4'd1;
              phase_nxt   = PH_RECV;
              timeout_nxt = timeout_reload_r;
            end
          end
          PH_RECV: begin
            if (word.rx_byte == CH_CR) begin
              phase_nxt = PH_CR;
            end else if (count_r < LINE_CAPACITY - 4'd1) begin
              store     = 1'b1;
              count_nxt = count_r + 4'd1;
            end else begin
              count_nxt = 4'd0;
            end
            timeout_nxt = timeout_reload_r;
          end
          PH_CR: begin
            if (word.rx_byte == CH_LF) begin
              // terminator lands at the current index
              store      = 1'b1;
              store_char = 8'd0;
              phase_nxt  = PH_DONE;
            end else begin
              phase_nxt = PH_RECV;
            end
            timeout_nxt = timeout_reload_r;
          end
          default: begin
            phase_nxt = PH_IDLE;
            count_nxt = 4'd0;
          end
        endcase
      end
      FN_TICK: begin
        if (waiting_r) begin
          if (phase_r == PH_DONE) begin
            phase_nxt = PH_IDLE;
            count_nxt = 4'd0;
            res_valid = 1'b1;
            if (first_r == CH_O && second_r == CH_K) begin
              waiting_nxt = 1'b0;
            end else begin
              fail = 1'b1;
            end
          end else if (phase_r != PH_IDLE && timeout_r != 16'd0) begin
            timeout_nxt = timeout_dec;
            if (timeout_dec == 16'd0) begin
              phase_nxt = PH_IDLE;
              count_nxt = 4'd0;
              res_valid = 1'b1;
              fail      = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase

    if (fail) begin
      if (attempt_r >= max_attempts_r) begin
        res.outcome = OUT_GAVEUP;
        waiting_nxt = 1'b0;
      end else begin
        res.outcome = OUT_RESEND;
        attempt_nxt = attempt_r + 4'd1;
      end
    end

    // only the first two characters are kept
    first_nxt  = (store && count_r == 4'd0) ? store_char : first_r;
    second_nxt = (store && count_r == 4'd1) ? store_char : second_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      count_r   <= 4'd0;
      first_r   <= 8'd0;
      second_r  <= 8'd0;
      timeout_r <= 16'd0;
      attempt_r <= 4'd0;
      waiting_r <= 1'b0;
    end else if (go) begin
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
      first_r   <= first_nxt;
      second_r  <= second_nxt;
      timeout_r <= timeout_nxt;
      attempt_r <= attempt_nxt;
      waiting_r <= waiting_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/crat_out_reg.sv -----
`default_nettype none
module crat_out_reg (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   word_valid,
  input  wire                   res_valid,
  input  crat_pkg::out_word_t   res,
  output logic                  advance,
  output logic                  out_valid,
  output crat_pkg::out_word_t   out_word,
  input  wire                   out_stall
);
  import crat_pkg::*;

  logic      valid_r;
  out_word_t word_r;

  // a word moves on when the result slot is empty or being taken
  assign advance   = word_valid && (!valid_r || !out_stall);
  assign out_valid = valid_r;
  assign out_word  = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= res_valid;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      word_r <= res;
    end
  end

endmodule
`default_nettype wire
